// ===== design/flog_pkg.sv =====
`timescale 1ns / 1ps

package flog_pkg;

    localparam int NUM_FMA   = 15;
    localparam int NUM_COEF  = 9;

    localparam logic [31:0] FP_NAN       = 32'h7fc0_0000;
    localparam logic [31:0] FP_NEG_INF   = 32'hff80_0000;
    localparam logic [31:0] FP_POS_INF   = 32'h7f80_0000;
    localparam logic [31:0] FP_NEG_ZERO  = 32'h8000_0000;
    localparam logic [31:0] FP_HALF      = 32'h3f00_0000;
    localparam logic [31:0] FP_ONE       = 32'h3f80_0000;
    localparam logic [31:0] FP_LN2_HI    = 32'h3f31_8000;
    localparam logic [31:0] FP_LN2_LO    = 32'hb95e_8083;
    localparam logic [22:0] SQRT_HALF_FRAC = 23'h35_04f3;

    localparam logic [31:0] COEF [NUM_COEF] = '{
        32'h3d90_21bb, 32'hbdeb_d1b8, 32'h3def_251a,
        32'hbdfe_5d4f, 32'h3e11_e9bf, 32'hbe2a_ae50,
        32'h3e4c_ceac, 32'hbe7f_fffc, 32'h3eaa_aaaa
    };

    // Values that ride along with each word through the arithmetic chain.
    typedef struct packed {
        logic [31:0] f;
        logic [31:0] e;
        logic [31:0] sq;
        logic        spec;
        logic [31:0] spec_bits;
        logic        last;
    } flog_side_t;

    // Position of the highest set bit; zero when no bit is set.
    function automatic logic [6:0] lead_pos(input logic [75:0] v);
        logic [6:0] p;
        p = '0;
        for (int i = 0; i < 76; i++)
        begin
            if (v[i])
                p = 7'(i);
        end
        return p;
    endfunction

endpackage

// ===== design/float32_natural_log_unit.sv =====
`timescale 1ns / 1ps

// Single-precision natural logarithm, one word per clock cycle sustained while
// the output queue has room. Each word passes a four-stage decode and range
// reduction, then fifteen fused multiply-add units of four stages each (square,
// eight polynomial steps, two products, then the ln2, -sq/2 and f terms),
// and a two-word output queue. When the output is stalled, the whole pipeline
// holds once the queue is full; s_tready depends only on the queue occupancy.
// NaN and negative inputs give 0x7fc00000, zeros give -infinity and +infinity
// passes through; tlast travels with its word.

module float32_natural_log_unit
    import flog_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] x_bits
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] log_bits
    output logic        m_tlast
);

    logic        en;
    logic        prep_valid;
    flog_side_t  prep_side;

    logic        iv [NUM_FMA];
    logic [31:0] ia [NUM_FMA];
    logic [31:0] ib [NUM_FMA];
    logic [31:0] ic [NUM_FMA];
    flog_side_t  isd [NUM_FMA];
    logic        ov [NUM_FMA];
    logic [31:0] oy [NUM_FMA];
    flog_side_t  osd [NUM_FMA];

    logic [31:0] result;

    assign s_tready = en;

    flog_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .x_bits    (s_tdata),
        .in_last   (s_tlast),
        .out_valid (prep_valid),
        .out_side  (prep_side)
    );

    // Operand routing for the chain of fused multiply-adds. A plain product
    // adds negative zero so that the sign of a zero product is kept.
    always_comb
    begin
        iv[0]  = prep_valid;
        isd[0] = prep_side;
        ia[0]  = prep_side.f;
        ib[0]  = prep_side.f;
        ic[0]  = FP_NEG_ZERO;
        for (int i = 1; i < NUM_FMA; i++)
        begin
            iv[i]  = ov[i-1];
            isd[i] = osd[i-1];
            ia[i]  = oy[i-1];
            ib[i]  = osd[i-1].f;
            ic[i]  = FP_NEG_ZERO;
        end
        isd[1].sq = oy[0];
        ia[1] = COEF[0];
        ic[1] = COEF[1];
        for (int i = 2; i < NUM_COEF; i++)
            ic[i] = COEF[i];
        ib[10] = osd[9].sq;
        ia[11] = osd[10].e;
        ib[11] = FP_LN2_LO;
        ic[11] = oy[10];
        ia[12] = {~osd[11].sq[31], osd[11].sq[30:0]};
        ib[12] = FP_HALF;
        ic[12] = oy[11];
        ia[13] = osd[12].f;
        ib[13] = FP_ONE;
        ic[13] = oy[12];
        ia[14] = osd[13].e;
        ib[14] = FP_LN2_HI;
        ic[14] = oy[13];
    end

    for (genvar gi = 0; gi < NUM_FMA; gi++)
    begin : g_fma
        flog_fma u_fma (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (iv[gi]),
            .a         (ia[gi]),
            .b         (ib[gi]),
            .c         (ic[gi]),
            .side_in   (isd[gi]),
            .out_valid (ov[gi]),
            .y         (oy[gi]),
            .side_out  (osd[gi])
        );
    end

    assign result = osd[NUM_FMA-1].spec ? osd[NUM_FMA-1].spec_bits : oy[NUM_FMA-1];

    flog_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (ov[NUM_FMA-1]),
        .in_data  (result),
        .in_last  (osd[NUM_FMA-1].last),
        .ready    (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== design/flog_prep.sv =====
`timescale 1ns / 1ps

module flog_prep
    import flog_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] x_bits,
    input  logic        in_last,
    output logic        out_valid,
    output flog_side_t  out_side
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [31:0] x1_reg;
    logic        last1_reg, last2_reg, last3_reg;
    logic [22:0] mant2_reg;
    logic signed [8:0] texp2_reg, e3_reg;
    logic        spec2_reg, spec3_reg;
    logic [31:0] specb2_reg, specb3_reg;
    logic [23:0] fmag3_reg;
    logic        fsign3_reg;
    flog_side_t  side4_reg;

    logic        sgn, is_nan, is_zero, is_sub;
    logic [7:0]  ex;
    logic [22:0] fr;
    logic [6:0]  k_sub;
    logic [4:0]  k5;
    logic [23:0] sub_norm;
    logic [22:0] mant_next;
    logic signed [8:0] texp_next;
    logic        spec_next;
    logic [31:0] specb_next;

    logic        nrm;
    logic [23:0] m24;
    logic [24:0] fm_n, fm_p;
    logic [23:0] fmag_next;
    logic signed [8:0] e_next;

    logic [6:0]  k_f, k_e;
    logic [4:0]  kf5;
    logic [2:0]  ke3;
    logic [23:0] f_sh, e_sh;
    logic [8:0]  emag;
    logic [7:0]  emag8;
    logic [31:0] f_bits, e_bits;
    flog_side_t  side_next;

    // Decode and classify; subnormals are normalized here.
    always_comb
    begin
        sgn      = x1_reg[31];
        ex       = x1_reg[30:23];
        fr       = x1_reg[22:0];
        is_nan   = (ex == 8'hff) && (fr != '0);
        is_zero  = (ex == 8'h00) && (fr == '0);
        is_sub   = !sgn && (ex == 8'h00) && (fr != '0);
        k_sub    = lead_pos({53'b0, fr});
        k5       = k_sub[4:0];
        sub_norm = {1'b0, fr} << (5'd23 - k5);
        mant_next = is_sub ? sub_norm[22:0] : fr;
        texp_next = is_sub ? ($signed({4'b0, k5}) - 9'sd149)
                           : ($signed({1'b0, ex}) - 9'sd127);
        spec_next  = 1'b1;
        specb_next = FP_NAN;
        if (is_nan || (sgn && !is_zero))
            specb_next = FP_NAN;
        else if (is_zero)
            specb_next = FP_NEG_INF;
        else if (x1_reg == FP_POS_INF)
            specb_next = FP_POS_INF;
        else
            spec_next = 1'b0;
    end

    // Mantissa range reduction; f is kept as an exact fixed-point magnitude.
    always_comb
    begin
        nrm  = mant2_reg < SQRT_HALF_FRAC;
        m24  = {1'b1, mant2_reg};
        fm_n = {m24, 1'b0} - 25'h100_0000;
        fm_p = 25'h100_0000 - {1'b0, m24};
        fmag_next = nrm ? fm_n[23:0] : fm_p[23:0];
        e_next = texp2_reg + 9'sd1 - (nrm ? 9'sd1 : 9'sd0);
    end

    // Exact conversion of f and e to single precision.
    always_comb
    begin
        k_f    = lead_pos({52'b0, fmag3_reg});
        kf5    = k_f[4:0];
        f_sh   = fmag3_reg << (5'd23 - kf5);
        f_bits = (fmag3_reg == '0) ? 32'h0
                 : {fsign3_reg, 8'd103 + {3'b0, kf5}, f_sh[22:0]};
        emag   = e3_reg[8] ? 9'(-e3_reg) : e3_reg;
        emag8  = emag[7:0];
        k_e    = lead_pos({68'b0, emag8});
        ke3    = k_e[2:0];
        e_sh   = {16'b0, emag8} << (5'd23 - {2'b0, ke3});
        e_bits = (emag8 == '0) ? 32'h0
                 : {e3_reg[8], 8'd127 + {5'b0, ke3}, e_sh[22:0]};
        side_next.f         = f_bits;
        side_next.e         = e_bits;
        side_next.sq        = '0;
        side_next.spec      = spec3_reg;
        side_next.spec_bits = specb3_reg;
        side_next.last      = last3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg     <= x_bits;
            last1_reg  <= in_last;
            mant2_reg  <= mant_next;
            texp2_reg  <= texp_next;
            spec2_reg  <= spec_next;
            specb2_reg <= specb_next;
            last2_reg  <= last1_reg;
            fmag3_reg  <= fmag_next;
            fsign3_reg <= !nrm;
            e3_reg     <= e_next;
            spec3_reg  <= spec2_reg;
            specb3_reg <= specb2_reg;
            last3_reg  <= last2_reg;
            side4_reg  <= side_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_side  = side4_reg;

endmodule

// ===== design/flog_fma.sv =====
`timescale 1ns / 1ps

module flog_fma
    import flog_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  flog_side_t  side_in,
    output logic        out_valid,
    output logic [31:0] y,
    output flog_side_t  side_out
);

    // Stage 1: product.
    logic        v1_reg;
    logic [47:0] prod1_reg;
    logic [8:0]  esum1_reg;
    logic        sp1_reg, pz1_reg, sc1_reg;
    logic [7:0]  ec1_reg;
    logic [23:0] mc1_reg;
    flog_side_t  side1_reg;

    // Stage 2: aligned sum.
    logic        v2_reg;
    logic [75:0] mag2_reg;
    logic        sgn2_reg, zs2_reg;
    logic signed [10:0] x2_reg;
    flog_side_t  side2_reg;

    // Stage 3: leading one.
    logic        v3_reg;
    logic [75:0] mag3_reg;
    logic [6:0]  k3_reg;
    logic        sgn3_reg, zs3_reg, nz3_reg;
    logic signed [10:0] x3_reg;
    flog_side_t  side3_reg;

    // Stage 4: rounded result.
    logic        v4_reg;
    logic [31:0] y4_reg;
    flog_side_t  side4_reg;

    logic [47:0] ma, mb, prod_next;
    logic [8:0]  esum_next;

    logic signed [10:0] sh_raw, x_next;
    logic        cz, anchor_c, sub, st_c, sgn_next;
    logic [6:0]  sh;
    logic [75:0] pw, cw, cs, mag_next;
    logic [24:0] lmask;
    logic [76:0] sum, d1, d2;

    logic [6:0]  k_next;

    logic [75:0] norm;
    logic [23:0] mant;
    logic        g, st_r, up;
    logic [24:0] mr;
    logic signed [10:0] eb;
    logic [22:0] frac;
    logic [31:0] y_next;

    always_comb
    begin
        ma = {24'b0, |a[30:23], a[22:0]};
        mb = {24'b0, |b[30:23], b[22:0]};
        prod_next = ma * mb;
        esum_next = {1'b0, a[30:23]} + {1'b0, b[30:23]};
    end

    // The addend starts 26 bits above the product and shifts right. When it
    // lies further up, the product only matters as a sticky bit below it.
    always_comb
    begin
        sh_raw   = $signed({2'b0, esum1_reg}) - $signed({3'b0, ec1_reg}) - 11'sd100;
        cz       = !mc1_reg[23];
        anchor_c = pz1_reg || (sh_raw < 0 && !cz);
        if (anchor_c)
            sh = 7'd0;
        else if (sh_raw > 11'sd75)
            sh = 7'd75;
        else
            sh = sh_raw[6:0];
        pw = anchor_c ? {75'b0, !pz1_reg && (prod1_reg != '0)}
                      : {27'b0, prod1_reg, 1'b0};
        cw = {1'b0, mc1_reg, 51'b0};
        lmask = (sh > 7'd51) ? ((25'd1 << (sh - 7'd51)) - 25'd1) : 25'd0;
        st_c  = |(mc1_reg & lmask[23:0]);
        cs    = (cw >> sh) | {75'b0, st_c};
        sub   = sp1_reg ^ sc1_reg;
        sum   = {1'b0, pw} + {1'b0, cs};
        d1    = {1'b0, pw} - {1'b0, cs};
        d2    = {1'b0, cs} - {1'b0, pw};
        if (!sub)
        begin
            mag_next = sum[75:0];
            sgn_next = sp1_reg;
        end
        else if (d1[76])
        begin
            mag_next = d2[75:0];
            sgn_next = sc1_reg;
        end
        else
        begin
            mag_next = d1[75:0];
            sgn_next = sp1_reg;
        end
        x_next = anchor_c ? ($signed({3'b0, ec1_reg}) - 11'sd201)
                          : ($signed({2'b0, esum1_reg}) - 11'sd301);
    end

    assign k_next = lead_pos(mag2_reg);

    // An exact zero is negative only when both terms were negative zeros.
    always_comb
    begin
        norm = mag3_reg << (7'd75 - k3_reg);
        mant = norm[75:52];
        g    = norm[51];
        st_r = |norm[50:0];
        up   = g && (st_r || mant[0]);
        mr   = {1'b0, mant} + {24'b0, up};
        eb   = x3_reg + $signed({4'b0, k3_reg}) + 11'sd127 + (mr[24] ? 11'sd1 : 11'sd0);
        frac = mr[24] ? 23'b0 : mr[22:0];
        y_next = nz3_reg ? {sgn3_reg, eb[7:0], frac} : {zs3_reg, 31'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= prod_next;
            esum1_reg <= esum_next;
            sp1_reg   <= a[31] ^ b[31];
            pz1_reg   <= (a[30:23] == '0) || (b[30:23] == '0);
            sc1_reg   <= c[31];
            ec1_reg   <= c[30:23];
            mc1_reg   <= {|c[30:23], c[22:0]};
            side1_reg <= side_in;

            mag2_reg  <= mag_next;
            sgn2_reg  <= sgn_next;
            zs2_reg   <= sp1_reg & sc1_reg;
            x2_reg    <= x_next;
            side2_reg <= side1_reg;

            mag3_reg  <= mag2_reg;
            k3_reg    <= k_next;
            sgn3_reg  <= sgn2_reg;
            zs3_reg   <= zs2_reg;
            nz3_reg   <= mag2_reg != '0;
            x3_reg    <= x2_reg;
            side3_reg <= side2_reg;

            y4_reg    <= y_next;
            side4_reg <= side3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign y         = y4_reg;
    assign side_out  = side4_reg;

endmodule

// ===== design/flog_outq.sv =====
`timescale 1ns / 1ps

module flog_outq
    import flog_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] in_data,
    input  logic        in_last,
    output logic        ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] d0_reg, d0_next, d1_reg, d1_next;
    logic        l0_reg, l0_next, l1_reg, l1_next;
    logic        push, pop;

    // Ready depends on occupancy alone, so the consumer never reaches upstream.
    assign ready    = cnt_reg != 2'd2;
    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = d0_reg;
    assign m_tlast  = l0_reg;
    assign push     = in_valid && ready;
    assign pop      = m_tvalid && m_tready;

    always_comb
    begin
        d0_next  = d0_reg;
        l0_next  = l0_reg;
        d1_next  = d1_reg;
        l1_next  = l1_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        if (pop)
        begin
            d0_next = d1_reg;
            l0_next = l1_reg;
        end
        if (push)
        begin
            if (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop))
            begin
                d0_next = in_data;
                l0_next = in_last;
            end
            else
            begin
                d1_next = in_data;
                l1_next = in_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        d0_reg <= d0_next;
        l0_reg <= l0_next;
        d1_reg <= d1_next;
        l1_reg <= l1_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output queue occupancy out of range");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> (cnt_reg == 2'd2))
        else $error("output queue changed while full and stalled");

    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 && push) |=>
            (m_tvalid && m_tdata == $past(in_data) && m_tlast == $past(in_last)))
        else $error("word written to an empty queue is not presented");

endmodule
